FILE: rtl/spdt_pkg.sv
// ----------------------------------------------------------------------------
// Script push-data tokenizer package
// Shared types, opcode constants and a length-field helper for the push-data tokenizer.
// ----------------------------------------------------------------------------
package spdt_pkg;

    localparam int OFFSET_BITS = 16;

    localparam logic [7:0] OP_PUSH_MIN   = 8'h01;
    localparam logic [7:0] OP_PUSH_MAX   = 8'h4B;
    localparam logic [7:0] OP_PUSHDATA1  = 8'h4C;
    localparam logic [7:0] OP_PUSHDATA2  = 8'h4D;
    localparam logic [7:0] OP_PUSHDATA4  = 8'h4E;

    typedef enum logic [1:0] {
        PH_OPCODE  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        CLS_OPCODE  = 2'd0,
        CLS_LENGTH  = 2'd1,
        CLS_PAYLOAD = 2'd2
    } byte_class_t;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       last_byte;
    } script_in_t;

    typedef struct packed {
        byte_class_t byte_class;
        logic [15:0] instr_offset;
        logic [7:0]  instr_opcode;
        logic [31:0] push_length;
        logic        overrun_error;
        logic        script_end;
    } token_out_t;

    function automatic logic [2:0] length_field_size(input logic [7:0] op);
        logic [2:0] size;
        case (op)
            OP_PUSHDATA1: size = 3'd1;
            OP_PUSHDATA2: size = 3'd2;
            default:      size = 3'd4;
        endcase
        return size;
    endfunction

endpackage

FILE: rtl/script_push_data_tokenizer.sv
// ----------------------------------------------------------------------------
// Script push-data tokenizer
// Classifies each script byte as opcode, length-field byte or payload byte.
// ----------------------------------------------------------------------------
// The block takes one script byte per clock cycle while the input is ready and
// returns one registered result per byte. The parse state is updated in the
// same cycle a byte is taken, so consecutive bytes stream at full rate.
// Results go into a two-entry output buffer. The input is ready whenever the
// second entry is empty, so a transaction taken while the output stalls is
// parked there. The input then pauses until that entry has moved up. After a
// byte marked as last, the next byte starts a new script at offset zero.
module script_push_data_tokenizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  spdt_pkg::script_in_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output spdt_pkg::token_out_t out_data
);
    import spdt_pkg::*;

    token_out_t result;
    logic       accept;

    logic       out_valid_reg, out_valid_next;
    token_out_t out_data_reg, out_data_next;
    logic       skid_valid_reg, skid_valid_next;
    token_out_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    spdt_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .in_data (in_data),
        .result  (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_data_next  = result;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid entry is only ever filled behind a held output entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output entry empty");

    // A transaction taken while the output stalls lands in the skid entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_valid_reg && !out_ready |=> skid_valid_reg)
        else $error("stalled transaction not buffered");

    // An overrun is only reported on the final byte of a script.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.overrun_error |-> out_data_reg.script_end)
        else $error("overrun reported before end of script");

endmodule

FILE: rtl/spdt_core.sv
// ----------------------------------------------------------------------------
// Script push-data tokenizer core
// Holds the parse state and classifies one script byte per step.
// ----------------------------------------------------------------------------
module spdt_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  spdt_pkg::script_in_t in_data,
    output spdt_pkg::token_out_t result
);
    import spdt_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             len_left_reg, len_left_next;
    logic [31:0]            accum_reg, accum_next;
    logic [31:0]            payload_left_reg, payload_left_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg, byte_offset_next;
    logic [OFFSET_BITS-1:0] start_offset_reg, start_offset_next;
    logic [7:0]             opcode_reg, opcode_next;

    logic [7:0]  b;
    logic        last;
    logic [2:0]  total;
    logic [2:0]  k;
    logic [2:0]  left_dec;
    logic [31:0] accum_or;
    logic [31:0] payload_dec;
    byte_class_t cls;
    logic [31:0] plen;
    logic        err;

    assign b        = in_data.script_byte;
    assign last     = in_data.last_byte;
    assign total    = length_field_size(opcode_reg);
    assign k        = (len_left_reg <= total && len_left_reg != 3'd0)
                    ? total - len_left_reg : 3'd0;
    assign accum_or = accum_reg | (32'(b) << {k[1:0], 3'b000});
    assign left_dec = (len_left_reg != 3'd0) ? len_left_reg - 3'd1 : 3'd0;
    assign payload_dec = (payload_left_reg != 32'd0) ? payload_left_reg - 32'd1 : 32'd0;

    always_comb
    begin
        phase_next        = phase_reg;
        len_left_next     = len_left_reg;
        accum_next        = accum_reg;
        payload_left_next = payload_left_reg;
        start_offset_next = start_offset_reg;
        opcode_next       = opcode_reg;
        cls               = CLS_OPCODE;
        plen              = 32'd0;
        err               = 1'b0;

        case (phase_reg)
            PH_LENGTH:
            begin
                cls           = CLS_LENGTH;
                accum_next    = accum_or;
                len_left_next = left_dec;
                if (left_dec == 3'd0)
                begin
                    plen              = accum_or;
                    payload_left_next = accum_or;
                    phase_next        = (accum_or != 32'd0) ? PH_PAYLOAD : PH_OPCODE;
                    err               = last && (accum_or != 32'd0);
                end
            end
            PH_PAYLOAD:
            begin
                cls               = CLS_PAYLOAD;
                plen              = accum_reg;
                payload_left_next = payload_dec;
                if (payload_dec == 32'd0)
                    phase_next = PH_OPCODE;
                else
                    err = last;
            end
            default:
            begin
                cls               = CLS_OPCODE;
                start_offset_next = byte_offset_reg;
                opcode_next       = b;
                phase_next        = PH_OPCODE;
                accum_next        = 32'd0;
                payload_left_next = 32'd0;
                if (b inside {[OP_PUSH_MIN:OP_PUSH_MAX]})
                begin
                    accum_next        = 32'(b);
                    payload_left_next = 32'(b);
                    plen              = 32'(b);
                    phase_next        = PH_PAYLOAD;
                    err               = last;
                end
                else if (b inside {[OP_PUSHDATA1:OP_PUSHDATA4]})
                begin
                    len_left_next = length_field_size(b);
                    phase_next    = PH_LENGTH;
                end
            end
        endcase

        result.byte_class    = cls;
        result.instr_offset  = 16'(start_offset_next);
        result.instr_opcode  = opcode_next;
        result.push_length   = plen;
        result.overrun_error = err;
        result.script_end    = last;

        if (last)
        begin
            phase_next        = PH_OPCODE;
            len_left_next     = 3'd0;
            accum_next        = 32'd0;
            payload_left_next = 32'd0;
            start_offset_next = '0;
            opcode_next       = 8'd0;
            byte_offset_next  = '0;
        end
        else
        begin
            byte_offset_next = byte_offset_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OPCODE;
            len_left_reg     <= 3'd0;
            accum_reg        <= 32'd0;
            payload_left_reg <= 32'd0;
            byte_offset_reg  <= '0;
            start_offset_reg <= '0;
            opcode_reg       <= 8'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            len_left_reg     <= len_left_next;
            accum_reg        <= accum_next;
            payload_left_reg <= payload_left_next;
            byte_offset_reg  <= byte_offset_next;
            start_offset_reg <= start_offset_next;
            opcode_reg       <= opcode_next;
        end
    end

    // A finished script leaves the parser at offset zero expecting an opcode.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && last |=> byte_offset_reg == '0 && phase_reg == PH_OPCODE)
        else $error("state not cleared after end of script");

    // While reading a length field, at least one length byte is still due.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_LENGTH |-> len_left_reg != 3'd0)
        else $error("length phase with no length bytes left");

    // While reading payload, at least one payload byte is still due.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> payload_left_reg != 32'd0)
        else $error("payload phase with no payload left");

endmodule
